// ===== hdl/lzss_pkg.sv =====
`timescale 1ns / 1ps
package lzss_pkg;

    localparam int WINDOW_DEPTH_DEF = 8192;
    localparam int OUT_LANES_DEF    = 4;
    localparam int WIN_W            = 13;
    localparam int CNT_W            = 14;
    localparam int MAX_LANES        = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] out_byte3;
        logic [2:0] out_count;
        logic       run_last;
        logic       stream_end;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FLUSH,
        ST_SEND,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        logic       push_lit;
        logic       rd_req;
        logic       push_rd;
        logic       flush;
        logic       clr_pack;
    } dp_cmd_t;

    typedef struct packed {
        logic       pack_full;
        logic       pack_empty;
    } dp_sts_t;

endpackage

// ===== hdl/lzss_datapath.sv =====
`timescale 1ns / 1ps
module lzss_datapath
    import lzss_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int OUT_LANES    = OUT_LANES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    input  logic [7:0]                lit_byte,
    input  logic [$clog2(WINDOW_DEPTH)-1:0] dist_off,
    output dp_sts_t                   sts,
    output logic [7:0]                lane_byte [MAX_LANES],
    output logic [2:0]                lane_cnt
);

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int LANES = (OUT_LANES > MAX_LANES) ? MAX_LANES : OUT_LANES;

    logic [7:0]    mem [WINDOW_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] wr_pos_reg;
    logic [7:0]    pack_reg [MAX_LANES];
    logic [2:0]    cnt_reg;
    logic [7:0]    wbyte;
    logic          push;

    assign push  = cmd.push_lit | cmd.push_rd;
    assign wbyte = cmd.push_lit ? lit_byte : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_pos_reg] <= wbyte;
        if (cmd.rd_req)
            rd_data_reg <= mem[wr_pos_reg - dist_off];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg <= '0;
            cnt_reg    <= '0;
            for (int i = 0; i < MAX_LANES; i++)
                pack_reg[i] <= 8'd0;
        end
        else
        begin
            if (push)
                wr_pos_reg <= wr_pos_reg + 1'b1;
            if (cmd.clr_pack)
                cnt_reg <= '0;
            else if (push)
                cnt_reg <= cnt_reg + 3'd1;
            for (int i = 0; i < MAX_LANES; i++)
            begin
                if (cmd.clr_pack)
                    pack_reg[i] <= 8'd0;
                else if (push && cnt_reg == 3'(i))
                    pack_reg[i] <= wbyte;
            end
        end
    end

    assign sts.pack_full  = (cnt_reg == 3'(LANES));
    assign sts.pack_empty = (cnt_reg == 3'd0);
    assign lane_byte      = pack_reg;
    assign lane_cnt       = cnt_reg;

endmodule

// ===== hdl/lzss_ctrl.sv =====
`timescale 1ns / 1ps
module lzss_ctrl
    import lzss_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_last,
    output logic        out_end,
    output dp_cmd_t     cmd,
    output logic [7:0]  lit_byte,
    output logic [$clog2(WINDOW_DEPTH)-1:0] dist_off,
    input  dp_sts_t     sts
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [3:0] PH_CWLO = 4'd0;
    localparam logic [3:0] PH_CWHI = 4'd5;
    localparam logic [3:0] PH_LIT  = 4'd10;
    localparam logic [3:0] PH_SD   = 4'd11;
    localparam logic [3:0] PH_WLO  = 4'd12;
    localparam logic [3:0] PH_WHI  = 4'd13;
    localparam logic [3:0] PH_EXT  = 4'd14;

    ctl_state_t state_reg, state_next;
    logic [15:0] cb_reg, cb_next;
    logic [4:0]  bl_reg, bl_next;
    logic [3:0]  ph_reg, ph_next;
    logic [7:0]  hlo_reg, hlo_next;
    logic [8:0]  plen_reg, plen_next;
    logic        fin_reg, fin_next;
    logic [CNT_W-1:0] prod_reg, prod_next;
    logic [8:0]  rem_reg, rem_next;
    logic [AW-1:0] dist_reg, dist_next;
    logic        end_reg, end_next;
    logic [7:0]  lit_reg, lit_next;
    logic        send_last_reg, send_last_next;
    logic        accept, push;

    assign accept = in_valid & in_ready;
    assign lit_byte = lit_reg;
    assign dist_off = dist_reg;

    always_comb
    begin
        logic [7:0]  b;
        logic        dec;
        logic [2:0]  s;
        logic        hb;
        logic        bit_v;
        logic        stop;
        logic [15:0] f;
        logic [8:0]  len;
        logic        cp;
        cb_next = cb_reg; bl_next = bl_reg; ph_next = ph_reg; hlo_next = hlo_reg;
        plen_next = plen_reg; fin_next = fin_reg; rem_next = rem_reg;
        dist_next = dist_reg; end_next = end_reg; lit_next = lit_reg;
        b = in_data.in_byte; dec = 1'b0; s = 3'd0; hb = 1'b0; bit_v = 1'b0;
        f = '0; len = '0; cp = 1'b0; stop = 1'b0;
        if (accept)
        begin
            if (ph_reg < PH_CWHI)
            begin
                hlo_next = b;
                ph_next  = ph_reg + PH_CWHI;
            end
            else if (ph_reg < PH_LIT)
            begin
                s = 3'(ph_reg - PH_CWHI);
                bit_v = cb_reg[0];
                cb_next = {b, hlo_reg};
                bl_next = 5'd16;
                dec = 1'b1;
                if (s == 3'd4)
                    s = 3'd0;
                else
                    hb = 1'b1;
            end
            else if (ph_reg == PH_LIT)
            begin
                lit_next = b;
                dec = 1'b1;
            end
            else if (ph_reg == PH_SD)
            begin
                f = 16'd256 - {8'd0, b};
                len = plen_reg;
                cp = 1'b1;
                dec = 1'b1;
            end
            else if (ph_reg == PH_WLO)
            begin
                hlo_next = b;
                ph_next  = PH_WHI;
            end
            else if (ph_reg == PH_WHI)
            begin
                if (b[2:0] == 3'd0)
                begin
                    plen_next = {4'd0, b[7:3]};
                    ph_next   = PH_EXT;
                end
                else
                begin
                    f = 16'd8192 - {3'd0, b[7:3], hlo_reg};
                    len = {6'd0, b[2:0]} + 9'd2;
                    cp = 1'b1;
                    dec = 1'b1;
                end
            end
            else if (ph_reg == PH_EXT)
            begin
                if (b <= 8'd1)
                    end_next = 1'b1;
                else
                begin
                    f = 16'd8192 - {3'd0, plen_reg[4:0], hlo_reg};
                    len = {1'b0, b} + 9'd1;
                    cp = 1'b1;
                    dec = 1'b1;
                end
            end
            if (dec)
            begin
                stop = 1'b0;
                for (int k = 0; k < 4; k++)
                begin
                    if (!stop)
                    begin
                        if (!hb)
                        begin
                            if (bl_next <= 5'd1)
                            begin
                                ph_next = PH_CWLO + 4'(s);
                                stop = 1'b1;
                            end
                            else
                            begin
                                bit_v = cb_next[0];
                                cb_next = cb_next >> 1;
                                bl_next = bl_next - 5'd1;
                            end
                        end
                        hb = 1'b0;
                        if (!stop)
                        begin
                            case (s)
                                3'd0:
                                begin
                                    if (bit_v) begin ph_next = PH_LIT; stop = 1'b1; end
                                    else s = 3'd1;
                                end
                                3'd1:
                                begin
                                    if (bit_v) begin ph_next = PH_WLO; stop = 1'b1; end
                                    else s = 3'd2;
                                end
                                3'd2:
                                begin
                                    plen_next = {8'd0, bit_v};
                                    s = 3'd3;
                                end
                                default:
                                begin
                                    plen_next = {7'd0, plen_next[0], bit_v} + 9'd2;
                                    ph_next = PH_SD;
                                    stop = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            end
            if (cp && f <= {2'd0, prod_reg})
            begin
                rem_next  = len;
                dist_next = AW'(f);
            end
            else
                rem_next = 9'd0;
            if (in_data.in_last)
                end_next = 1'b1;
        end
        else
        begin
            if (state_reg == ST_COPY_WR && rem_reg != 9'd0)
                rem_next = rem_reg - 9'd1;
        end
        if (state_reg == ST_IDLE && accept && (end_next || in_data.in_last))
            fin_next = 1'b1;
    end

    assign push = cmd.push_lit | cmd.push_rd;
    assign prod_next = (push && prod_reg < CNT_W'(WINDOW_DEPTH)) ? prod_reg + 1'b1 : prod_reg;

    always_comb
    begin
        state_next = state_reg;
        send_last_next = send_last_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (ph_reg == PH_LIT && !fin_reg)
                        state_next = ST_COPY_RD;
                    else
                        state_next = (rem_next != 9'd0) ? ST_COPY_RD : ST_FLUSH;
                end
            ST_COPY_RD:
                if (sts.pack_full)
                begin
                    send_last_next = 1'b0;
                    state_next = ST_SEND;
                end
                else
                    state_next = ST_COPY_WR;
            ST_COPY_WR:
                if (rem_reg <= 9'd1)
                    state_next = ST_FLUSH;
                else
                    state_next = ST_COPY_RD;
            ST_FLUSH:
                if (!sts.pack_empty || end_reg)
                begin
                    send_last_next = 1'b1;
                    state_next = ST_SEND;
                end
                else
                    state_next = fin_reg ? ST_DONE : ST_IDLE;
            ST_SEND:
                if (out_ready)
                begin
                    if (send_last_reg)
                        state_next = fin_reg ? ST_DONE : ST_IDLE;
                    else if (rem_reg != 9'd0)
                        state_next = ST_COPY_RD;
                    else
                        state_next = ST_FLUSH;
                end
            ST_DONE:
                state_next = ST_DONE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    logic lit_pend_reg, lit_pend_next;

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        out_last = send_last_reg;
        out_end = send_last_reg & end_reg;
        lit_pend_next = lit_pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !fin_reg;
                lit_pend_next = accept && ph_reg == PH_LIT;
            end
            ST_COPY_RD:
                cmd.rd_req = !lit_pend_reg && !sts.pack_full;
            ST_COPY_WR:
            begin
                cmd.push_lit = lit_pend_reg;
                cmd.push_rd  = !lit_pend_reg && rem_reg != 9'd0;
                lit_pend_next = 1'b0;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                cmd.clr_pack = out_ready;
            end
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cb_reg        <= '0;
            bl_reg        <= 5'd16;
            ph_reg        <= PH_CWLO + 4'd4;
            hlo_reg       <= '0;
            plen_reg      <= '0;
            fin_reg       <= 1'b0;
            prod_reg      <= '0;
            rem_reg       <= '0;
            dist_reg      <= '0;
            end_reg       <= 1'b0;
            lit_reg       <= '0;
            send_last_reg <= 1'b0;
            lit_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cb_reg        <= cb_next;
            bl_reg        <= bl_next;
            ph_reg        <= ph_next;
            hlo_reg       <= hlo_next;
            plen_reg      <= plen_next;
            fin_reg       <= fin_next;
            prod_reg      <= prod_next;
            rem_reg       <= rem_next;
            dist_reg      <= dist_next;
            end_reg       <= end_next;
            lit_reg       <= lit_next;
            send_last_reg <= send_last_next;
            lit_pend_reg  <= lit_pend_next;
        end
    end

endmodule

// ===== hdl/lzss_byte_stream_decompressor.sv =====
`timescale 1ns / 1ps
// One compressed byte at a time: a new input byte is taken only in the idle
// state, after every result of the last byte has been transferred. Each
// decompressed byte is written to the history and packed into the lanes, and
// a result is sent when the lanes are full or the byte's output is flushed.
// Reset: asynchronous, active low; history contents stay undefined, all
// control and parser state returns to the first control word.
module lzss_byte_stream_decompressor
    import lzss_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int OUT_LANES    = OUT_LANES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    dp_cmd_t    cmd;
    dp_sts_t    sts;
    logic [7:0] lit_byte;
    logic [$clog2(WINDOW_DEPTH)-1:0] dist_off;
    logic [7:0] lane_byte [MAX_LANES];
    logic [2:0] lane_cnt;
    logic       out_last, out_end;

    lzss_ctrl #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_last(out_last), .out_end(out_end),
        .cmd(cmd), .lit_byte(lit_byte), .dist_off(dist_off), .sts(sts)
    );

    lzss_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH), .OUT_LANES(OUT_LANES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .lit_byte(lit_byte),
        .dist_off(dist_off), .sts(sts), .lane_byte(lane_byte), .lane_cnt(lane_cnt)
    );

    assign out_data.out_byte0  = lane_byte[0];
    assign out_data.out_byte1  = lane_byte[1];
    assign out_data.out_byte2  = lane_byte[2];
    assign out_data.out_byte3  = lane_byte[3];
    assign out_data.out_count  = lane_cnt;
    assign out_data.run_last   = out_last;
    assign out_data.stream_end = out_end;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input and output overlap");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.out_count <= 3'(MAX_LANES)) else $error("count range");
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.stream_end |-> out_data.run_last) else $error("end without last");

endmodule
